### hdl/hvd_pkg.sv
// ----------------------------------------------------------------------------
// hvd_pkg: shared types, constants and elaboration-time helpers
// Holds the fixed-point constants, the pipeline depths and the functions
// that build the CORDIC arctangent table and gain correction.
// ----------------------------------------------------------------------------
package hvd_pkg;

  // Pipeline depths.
  localparam int CORDIC_ITERS = 62;
  localparam int SQRT_STEPS   = 63;
  localparam int MUL_LAT      = 2;
  localparam int SC_LAT       = 7 + CORDIC_ITERS + 1;
  localparam int PIPE_LAT     = 1 + SC_LAT + 1 + 3 * MUL_LAT + 2 + 3 + SQRT_STEPS
                                + CORDIC_ITERS + 3;

  // Angle in half-microdegree units, and a Q3.61 word.
  typedef logic signed [29:0] angle_t;
  typedef logic [63:0] q61_t;

  // Angle unit constants.
  localparam logic [27:0] QUAD_UNITS = 28'd180000000;
  localparam logic [27:0] HALF_QUAD  = 28'd90000000;
  localparam logic [30:0] QUAD_1     = 31'd180000000;
  localparam logic [30:0] QUAD_2     = 31'd360000000;
  localparam logic [30:0] QUAD_3     = 31'd540000000;
  localparam logic [29:0] FULL_UNITS = 30'd720000000;

  // Fixed-point constants.
  localparam logic [61:0]  HALFPI_Q61    = 62'h3243F6A8885A308D;
  localparam logic [63:0]  QUARTERPI_Q61 = 64'h1921FB54442D1847;
  localparam logic [122:0] ONE_Q122      = 123'(1) << 122;
  localparam logic [29:0]  RADIUS_RESET  = 30'd637279756;

  // pi/2 split as quotient and remainder by the quadrant size, and the
  // reciprocal of the quadrant size scaled by 2^55.
  localparam logic [34:0] HALFPI_DIV = 35'(64'(HALFPI_Q61) / 64'(QUAD_UNITS));
  localparam logic [27:0] HALFPI_MOD = 28'(64'(HALFPI_Q61) % 64'(QUAD_UNITS));
  localparam logic [27:0] QUAD_RECIP = 28'((64'(1) << 55) / 64'(QUAD_UNITS));

  // Arithmetic shift right of a two's-complement word.
  function automatic logic [63:0] asr64(input logic [63:0] u, input int s);
    return 64'($signed(u) >>> s);
  endfunction

  // Magnitude of a two's-complement word.
  function automatic logic [63:0] mag64(input logic [63:0] u);
    return u[63] ? (64'd0 - u) : u;
  endfunction

  // Shift-subtract quotient, used only while building constants.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      q = q << 1;
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Arctangent of 2^-i in Q61, summed from its series in Q62 and rounded.
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] t;
    int e;
    pos = '0;
    neg = '0;
    if (i == 0) return QUARTERPI_Q61;
    for (int k = 0; 62 - i * (2 * k + 1) >= 0; k++) begin
      e = 62 - i * (2 * k + 1);
      t = udiv64(64'(1) << e, 64'(2 * k + 1));
      if (k[0] == 1'b0) pos = pos + t;
      else neg = neg + t;
    end
    return ((pos - neg) + 64'd1) >> 1;
  endfunction

  // Reciprocal of the CORDIC gain in Q61, rounded to nearest.
  function automatic logic [63:0] calc_gain_inv();
    logic [63:0]  x;
    logic [63:0]  y;
    logic [63:0]  z;
    logic [63:0]  xs;
    logic [63:0]  ys;
    logic [63:0]  a;
    logic [63:0]  q;
    logic [127:0] n;
    logic [64:0]  r;
    x = 64'(1) << 61;
    y = '0;
    z = '0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = asr64(x, i);
      ys = asr64(y, i);
      a  = atan_entry(i);
      if (!z[63]) begin
        x = x - ys;
        y = y + xs;
        z = z - a;
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + a;
      end
    end
    n = (128'(1) << 122) + 128'(x >> 1);
    q = '0;
    r = '0;
    for (int i = 127; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      q = q << 1;
      if (r >= {1'b0, x}) begin
        r    = r - {1'b0, x};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  localparam logic [63:0] GAIN_INV = calc_gain_inv();

endpackage

### hdl/hvd_mul64.sv
// ----------------------------------------------------------------------------
// hvd_mul64: pipelined 64 x 64 unsigned multiplier
// Four 32 x 32 partial products in the first stage, their sum in the second.
// ----------------------------------------------------------------------------
module hvd_mul64 (
  input  logic         clk,
  input  logic         en,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] p
);
  import hvd_pkg::*;

  logic [63:0] p00;
  logic [63:0] p01;
  logic [63:0] p10;
  logic [63:0] p11;

  // Partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= 64'(a[31:0]) * 64'(b[31:0]);
      p01 <= 64'(a[31:0]) * 64'(b[63:32]);
      p10 <= 64'(a[63:32]) * 64'(b[31:0]);
      p11 <= 64'(a[63:32]) * 64'(b[63:32]);
    end
  end

  // Sum of the aligned partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      p <= (128'(p11) << 64) + (128'(p01) << 32) + (128'(p10) << 32) + 128'(p00);
    end
  end

endmodule

### hdl/hvd_sincos.sv
// ----------------------------------------------------------------------------
// hvd_sincos: pipelined sine and cosine of an angle in half-microdegrees
// Folds the angle to a quadrant, converts it to Q61 radians by reciprocal
// multiplication, rotates with a CORDIC and maps the result back to its
// quadrant.
// ----------------------------------------------------------------------------
module hvd_sincos (
  input  logic           clk,
  input  logic           en,
  input  hvd_pkg::angle_t angle,
  output hvd_pkg::q61_t  cos_q,
  output hvd_pkg::q61_t  sin_q
);
  import hvd_pkg::*;

  logic [29:0] turn;
  logic [30:0] d1;
  logic [30:0] d2;
  logic [30:0] d3;
  logic [1:0]  qsel;
  logic [27:0] rsel;
  logic [27:0] rq;
  logic [1:0]  qb;

  logic [58:0] ra_lo;
  logic [31:0] ra_hi;
  logic [55:0] n2;
  logic [1:0]  qc;

  logic [61:0] base_b;
  logic [59:0] pe_lo;
  logic [51:0] pe_hi;
  logic [55:0] n2_b;
  logic [1:0]  q_b;

  logic [83:0] pe_sum;
  logic [61:0] base_c;
  logic [27:0] qe;
  logic [55:0] n2_c;
  logic [1:0]  q_c;

  logic [61:0] base_d;
  logic [27:0] qe_d;
  logic [55:0] qq;
  logic [55:0] n2_d;
  logic [1:0]  q_d;
  logic [55:0] rem_d;

  logic [61:0] theta;
  logic [1:0]  qt;

  logic [63:0] cr_x    [CORDIC_ITERS];
  logic [63:0] cr_y    [CORDIC_ITERS];
  logic [63:0] cr_z    [CORDIC_ITERS];
  logic [1:0]  cr_quad [CORDIC_ITERS];

  // Fold the angle into one full turn.
  always_ff @(posedge clk) begin
    if (en) begin
      turn <= angle[29] ? 30'({angle[29], angle} + {1'b0, FULL_UNITS}) : angle;
    end
  end

  // Split the turn into quadrant and remainder.
  assign d1 = {1'b0, turn} - QUAD_1;
  assign d2 = {1'b0, turn} - QUAD_2;
  assign d3 = {1'b0, turn} - QUAD_3;

  always_comb begin
    if (!d3[30]) begin
      qsel = 2'd3;
      rsel = d3[27:0];
    end else if (!d2[30]) begin
      qsel = 2'd2;
      rsel = d2[27:0];
    end else if (!d1[30]) begin
      qsel = 2'd1;
      rsel = d1[27:0];
    end else begin
      qsel = 2'd0;
      rsel = turn[27:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rq <= rsel;
      qb <= qsel;
    end
  end

  // With pi/2 = Q*h1 + h0, the rounded quotient is r*h1 plus the rounded
  // quotient of r*h0 + Q/2 by Q, which stays below 2^55.
  always_ff @(posedge clk) begin
    if (en) begin
      ra_lo <= 59'(rq) * 59'(HALFPI_DIV[30:0]);
      ra_hi <= 32'(rq) * 32'(HALFPI_DIV[34:31]);
      n2    <= 56'(rq) * 56'(HALFPI_MOD) + 56'(HALF_QUAD);
      qc    <= qb;
    end
  end

  // Sum r*h1, and multiply the small dividend by the scaled reciprocal.
  always_ff @(posedge clk) begin
    if (en) begin
      base_b <= (62'(ra_hi) << 31) + 62'(ra_lo);
      pe_lo  <= 60'(n2[31:0]) * 60'(QUAD_RECIP);
      pe_hi  <= 52'(n2[55:32]) * 52'(QUAD_RECIP);
      n2_b   <= n2;
      q_b    <= qc;
    end
  end

  // Quotient estimate, at most one below the true quotient.
  assign pe_sum = (84'(pe_hi) << 32) + 84'(pe_lo);

  always_ff @(posedge clk) begin
    if (en) begin
      base_c <= base_b;
      qe     <= pe_sum[82:55];
      n2_c   <= n2_b;
      q_c    <= q_b;
    end
  end

  // Multiply the estimate back by the quadrant size.
  always_ff @(posedge clk) begin
    if (en) begin
      base_d <= base_c;
      qe_d   <= qe;
      qq     <= 56'(qe) * 56'(QUAD_UNITS);
      n2_d   <= n2_c;
      q_d    <= q_c;
    end
  end

  // Correct the estimate by one where the remainder reaches the divisor.
  assign rem_d = n2_d - qq;

  always_ff @(posedge clk) begin
    if (en) begin
      theta <= base_d + 62'(qe_d) + {61'd0, rem_d >= 56'(QUAD_UNITS)};
      qt    <= q_d;
    end
  end

  // Rotation-mode CORDIC, one micro-rotation per stage.
  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_rot
    localparam logic [63:0] ANG = atan_entry(i);
    logic [63:0] x_i;
    logic [63:0] y_i;
    logic [63:0] z_i;
    logic [1:0]  quad_i;
    logic [63:0] xs;
    logic [63:0] ys;
    if (i == 0) begin : g_first
      assign x_i    = GAIN_INV;
      assign y_i    = '0;
      assign z_i    = {2'b00, theta};
      assign quad_i = qt;
    end else begin : g_next
      assign x_i    = cr_x[i-1];
      assign y_i    = cr_y[i-1];
      assign z_i    = cr_z[i-1];
      assign quad_i = cr_quad[i-1];
    end
    assign xs = asr64(x_i, i);
    assign ys = asr64(y_i, i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_i[63]) begin
          cr_x[i] <= x_i - ys;
          cr_y[i] <= y_i + xs;
          cr_z[i] <= z_i - ANG;
        end else begin
          cr_x[i] <= x_i + ys;
          cr_y[i] <= y_i - xs;
          cr_z[i] <= z_i + ANG;
        end
        cr_quad[i] <= quad_i;
      end
    end
  end

  // Map the first-quadrant result back to the original quadrant.
  always_ff @(posedge clk) begin
    if (en) begin
      case (cr_quad[CORDIC_ITERS-1])
        2'd0: begin
          cos_q <= cr_x[CORDIC_ITERS-1];
          sin_q <= cr_y[CORDIC_ITERS-1];
        end
        2'd1: begin
          cos_q <= 64'd0 - cr_y[CORDIC_ITERS-1];
          sin_q <= cr_x[CORDIC_ITERS-1];
        end
        2'd2: begin
          cos_q <= 64'd0 - cr_x[CORDIC_ITERS-1];
          sin_q <= 64'd0 - cr_y[CORDIC_ITERS-1];
        end
        default: begin
          cos_q <= cr_y[CORDIC_ITERS-1];
          sin_q <= 64'd0 - cr_x[CORDIC_ITERS-1];
        end
      endcase
    end
  end

endmodule

### hdl/haversine_distance.sv
// ----------------------------------------------------------------------------
// haversine_distance: great-circle distance of two points, fully pipelined
//
// Input channel (in_valid/in_ready) carries one beat per point pair:
// latitude and longitude of both points in signed microdegrees. Output
// channel (out_valid/out_ready) carries one beat per pair: the distance in
// centimeters, rounded to nearest. Beats leave in the order they entered.
// A new pair is taken every cycle while the output is not held. The pipeline
// depth is set by the radian conversion and CORDIC in the sine/cosine lanes,
// the square-root stages and the arctangent CORDIC. The sphere radius is
// written through cfg_wen/cfg_wdata; the user must write it only while the
// block is idle (not enforced by the block); reset loads the default radius.
// The whole pipeline advances under one enable. While the output beat waits
// for out_ready, in_ready is low and every stage holds, so nothing is lost
// or repeated. Reset clears all valid bits, leaving the pipeline empty.
// ----------------------------------------------------------------------------
module haversine_distance (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [27:0] lat_a,
  input  logic [28:0] lon_a,
  input  logic [27:0] lat_b,
  input  logic [28:0] lon_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] distance_cm,
  input  logic        cfg_wen,
  input  logic [29:0] cfg_wdata
);
  import hvd_pkg::*;

  localparam int K_A2 = SC_LAT + 11;

  logic                adv;
  logic [PIPE_LAT-1:0] vld;
  logic [29:0]         radius;

  angle_t      ang   [4];
  q61_t        sc_c  [2];
  q61_t        sc_s  [2];

  logic [63:0]  m_ca;
  logic [63:0]  m_cb;
  logic [63:0]  m_sl;
  logic [63:0]  m_so;
  logic         m_neg;
  logic [127:0] p_u;
  logic [127:0] p_sq;
  logic [63:0]  lon1;
  logic [63:0]  lon2;
  logic         neg1;
  logic         neg2;
  logic [127:0] rnd_u;
  logic [63:0]  u_r;
  logic [127:0] sq_r1;
  logic [63:0]  lon_r1;
  logic         neg_r1;
  logic [127:0] p_v;
  logic [127:0] sq_3a;
  logic [127:0] sq_3b;
  logic [63:0]  lon_3a;
  logic [63:0]  lon_3b;
  logic         neg_3a;
  logic         neg_3b;
  logic [127:0] rnd_v;
  logic [63:0]  v_r;
  logic [127:0] sq_r2;
  logic [63:0]  lon_r2;
  logic         neg_r2;
  logic [127:0] p_w;
  logic [127:0] sq_4a;
  logic [127:0] sq_4b;
  logic         neg_4a;
  logic         neg_4b;
  logic [128:0] diff;
  logic [127:0] s1;
  logic [122:0] a2;
  logic [122:0] a3_a;
  logic [122:0] a3_b;

  logic [122:0] sq_rem [SQRT_STEPS][2];
  logic [62:0]  sq_res [SQRT_STEPS][2];

  logic [63:0] cv_x [CORDIC_ITERS];
  logic [63:0] cv_y [CORDIC_ITERS];
  logic [63:0] cv_z [CORDIC_ITERS];

  logic [62:0] zc;
  logic [61:0] rp_lo;
  logic [60:0] rp_hi;
  logic [93:0] prod;

  // Global advance: stall only when the output beat is held.
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[PIPE_LAT-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  // Radius register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_wen) begin
      radius <= cfg_wdata;
    end
  end

  // Input stage: the four angles in half-microdegree units.
  always_ff @(posedge clk) begin
    if (adv) begin
      ang[0] <= {lat_a[27], lat_a, 1'b0};
      ang[1] <= {lat_b[27], lat_b, 1'b0};
      ang[2] <= {{2{lat_a[27]}}, lat_a} - {{2{lat_b[27]}}, lat_b};
      ang[3] <= {lon_a[28], lon_a} - {lon_b[28], lon_b};
    end
  end

  // Sine and cosine lanes.
  hvd_sincos u_sc_lat_a (.clk(clk), .en(adv), .angle(ang[0]), .cos_q(sc_c[0]), .sin_q());
  hvd_sincos u_sc_lat_b (.clk(clk), .en(adv), .angle(ang[1]), .cos_q(sc_c[1]), .sin_q());
  hvd_sincos u_sc_dlat  (.clk(clk), .en(adv), .angle(ang[2]), .cos_q(), .sin_q(sc_s[0]));
  hvd_sincos u_sc_dlon  (.clk(clk), .en(adv), .angle(ang[3]), .cos_q(), .sin_q(sc_s[1]));

  // Magnitudes and the sign of the cosine product.
  always_ff @(posedge clk) begin
    if (adv) begin
      m_ca  <= mag64(sc_c[0]);
      m_cb  <= mag64(sc_c[1]);
      m_sl  <= mag64(sc_s[0]);
      m_so  <= mag64(sc_s[1]);
      m_neg <= sc_c[0][63] ^ sc_c[1][63];
    end
  end

  hvd_mul64 u_mul_cc (.clk(clk), .en(adv), .a(m_ca), .b(m_cb), .p(p_u));
  hvd_mul64 u_mul_sq (.clk(clk), .en(adv), .a(m_sl), .b(m_sl), .p(p_sq));

  // Round cos*cos to Q61.
  assign rnd_u = p_u + (128'(1) << 60);

  always_ff @(posedge clk) begin
    if (adv) begin
      lon1   <= m_so;
      neg1   <= m_neg;
      lon2   <= lon1;
      neg2   <= neg1;
      u_r    <= rnd_u[124:61];
      sq_r1  <= p_sq;
      lon_r1 <= lon2;
      neg_r1 <= neg2;
    end
  end

  hvd_mul64 u_mul_v (.clk(clk), .en(adv), .a(u_r), .b(lon_r1), .p(p_v));

  // Round (cos*cos)*|sin| to Q61.
  assign rnd_v = p_v + (128'(1) << 60);

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_3a  <= sq_r1;
      lon_3a <= lon_r1;
      neg_3a <= neg_r1;
      sq_3b  <= sq_3a;
      lon_3b <= lon_3a;
      neg_3b <= neg_3a;
      v_r    <= rnd_v[124:61];
      sq_r2  <= sq_3b;
      lon_r2 <= lon_3b;
      neg_r2 <= neg_3b;
    end
  end

  hvd_mul64 u_mul_w (.clk(clk), .en(adv), .a(v_r), .b(lon_r2), .p(p_w));

  // Form a in Q122, clamp it to [0, 1] and take 1 - a.
  assign diff = {1'b0, sq_4b} - {1'b0, p_w};

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_4a  <= sq_r2;
      neg_4a <= neg_r2;
      sq_4b  <= sq_4a;
      neg_4b <= neg_4a;
      if (neg_4b) begin
        s1 <= diff[128] ? '0 : diff[127:0];
      end else begin
        s1 <= sq_4b + p_w;
      end
      a2   <= (s1 > 128'(ONE_Q122)) ? ONE_Q122 : s1[122:0];
      a3_a <= a2;
      a3_b <= ONE_Q122 - a2;
    end
  end

  // Floor square roots of a and 1 - a, one result bit per stage.
  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
    localparam int B = SQRT_STEPS - 1 - s;
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [122:0] rem_i;
      logic [62:0]  res_i;
      logic [127:0] term;
      logic         ge;
      if (s == 0) begin : g_first
        assign rem_i = (l == 0) ? a3_a : a3_b;
        assign res_i = '0;
      end else begin : g_next
        assign rem_i = sq_rem[s-1][l];
        assign res_i = sq_res[s-1][l];
      end
      assign term = (128'(res_i) << (B + 1)) | (128'(1) << (2 * B));
      assign ge   = 128'(rem_i) >= term;
      always_ff @(posedge clk) begin
        if (adv) begin
          sq_rem[s][l] <= ge ? (rem_i - 123'(term)) : rem_i;
          sq_res[s][l] <= ge ? (res_i | (63'(1) << B)) : res_i;
        end
      end
    end
  end

  // Vectoring CORDIC for atan2(sqrt(a), sqrt(1 - a)).
  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_vec
    localparam logic [63:0] ANG = atan_entry(i);
    logic [63:0] x_i;
    logic [63:0] y_i;
    logic [63:0] z_i;
    logic [63:0] xs;
    logic [63:0] ys;
    if (i == 0) begin : g_first
      assign x_i = {1'b0, sq_res[SQRT_STEPS-1][1]};
      assign y_i = {1'b0, sq_res[SQRT_STEPS-1][0]};
      assign z_i = '0;
    end else begin : g_next
      assign x_i = cv_x[i-1];
      assign y_i = cv_y[i-1];
      assign z_i = cv_z[i-1];
    end
    assign xs = asr64(x_i, i);
    assign ys = asr64(y_i, i);
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!y_i[63]) begin
          cv_x[i] <= x_i + ys;
          cv_y[i] <= y_i - xs;
          cv_z[i] <= z_i + ANG;
        end else begin
          cv_x[i] <= x_i - ys;
          cv_y[i] <= y_i + xs;
          cv_z[i] <= z_i - ANG;
        end
      end
    end
  end

  // Scale the angle by the radius, round and saturate.
  assign prod = (94'(rp_hi) << 32) + 94'(rp_lo) + (94'(1) << 59);

  always_ff @(posedge clk) begin
    if (adv) begin
      zc          <= cv_z[CORDIC_ITERS-1][63] ? '0 : cv_z[CORDIC_ITERS-1][62:0];
      rp_lo       <= 62'(radius) * 62'(zc[31:0]);
      rp_hi       <= 61'(radius) * 61'(zc[62:32]);
      distance_cm <= (|prod[93:92]) ? 32'hFFFF_FFFF : prod[91:60];
    end
  end

  // The pipeline is empty right after reset.
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // A stall freezes every valid bit.
  assert property (@(posedge clk) disable iff (rst) !in_ready |=> $stable(vld))
    else $error("valid bits moved during a stall");

  // The clamped haversine term never exceeds one.
  assert property (@(posedge clk) disable iff (rst) vld[K_A2] |-> (a2 <= ONE_Q122))
    else $error("haversine term above one");

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for haversine_distance
// Point pairs are driven through the input channel and every distance
// beat is compared with a bit-exact fixed-point predictor of the pipeline.
// The sphere radius is changed between phases while the block is idle.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  import hvd_pkg::*;

  localparam int CORDIC_N  = 62;
  localparam int DRAIN_CYC = 320;
  localparam int CYCLE_CAP = 400000;
  localparam int N_PHASES  = 6;
  localparam int PHASE_LEN = 230;

  typedef struct packed {
    logic [27:0] la;
    logic [28:0] loa;
    logic [27:0] lb;
    logic [28:0] lob;
  } pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [27:0] lat_a = '0;
  logic [28:0] lon_a = '0;
  logic [27:0] lat_b = '0;
  logic [28:0] lon_b = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] distance_cm;
  logic        cfg_wen = 1'b0;
  logic [29:0] cfg_wdata = '0;

  pair_t       pend_pairs[$];
  logic [31:0] dist_expected[$];
  logic [63:0] arctan_q61[CORDIC_N];
  logic [63:0] inv_gain;
  logic [29:0] radius_cm = RADIUS_RESET;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_send = 1'b0;
  int          queued_cnt = 0;
  int          accepted_cnt = 0;
  int          done_cnt = 0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;

  haversine_distance u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
    .out_valid(out_valid), .out_ready(out_ready), .distance_cm(distance_cm),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] shift_signed(logic [63:0] u, int s);
    return 64'($signed(u) >>> s);
  endfunction

  function automatic logic [63:0] abs_q61(logic [63:0] u);
    return u[63] ? 64'd0 - u : u;
  endfunction

  // Rotation-mode CORDIC, x and y updated in place.
  task automatic rotate_vec(inout logic [63:0] x, inout logic [63:0] y,
                            input logic [63:0] z);
    logic [63:0] xs;
    logic [63:0] ys;
    for (int i = 0; i < CORDIC_N; i++) begin
      xs = shift_signed(x, i);
      ys = shift_signed(y, i);
      if (!z[63]) begin
        x = x - ys; y = y + xs; z = z - arctan_q61[i];
      end else begin
        x = x + ys; y = y - xs; z = z + arctan_q61[i];
      end
    end
  endtask

  // Vectoring-mode CORDIC, returns the accumulated angle.
  function automatic logic [63:0] vector_angle(logic [63:0] x, logic [63:0] y);
    logic [63:0] xs;
    logic [63:0] ys;
    logic [63:0] z;
    z = '0;
    for (int i = 0; i < CORDIC_N; i++) begin
      xs = shift_signed(x, i);
      ys = shift_signed(y, i);
      if (!y[63]) begin
        x = x + ys; y = y - xs; z = z + arctan_q61[i];
      end else begin
        x = x - ys; y = y + xs; z = z - arctan_q61[i];
      end
    end
    return z;
  endfunction

  // Arctangent table by series sums and the inverse gain, built once.
  task automatic build_trig_tables();
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] x;
    logic [63:0] y;
    logic [127:0] num;
    int e;
    arctan_q61[0] = 64'h1921FB54442D1847;
    for (int i = 1; i < CORDIC_N; i++) begin
      pos = '0;
      neg = '0;
      for (int k = 0; 62 - i * (2 * k + 1) >= 0; k++) begin
        e = 62 - i * (2 * k + 1);
        if (k % 2 == 0) pos = pos + (64'd1 << e) / 64'(2 * k + 1);
        else neg = neg + (64'd1 << e) / 64'(2 * k + 1);
      end
      arctan_q61[i] = ((pos - neg) + 64'd1) >> 1;
    end
    x = 64'd1 << 61;
    y = '0;
    rotate_vec(x, y, 64'd0);
    num = (128'd1 << 122) + 128'(x >> 1);
    inv_gain = 64'(num / 128'(x));
  endtask

  // Cosine and sine of an angle in half-microdegree units, Q61.
  task automatic sin_cos(input longint n, output logic [63:0] c, output logic [63:0] s);
    longint m;
    longint q;
    longint r;
    logic [127:0] th;
    logic [63:0] x;
    logic [63:0] y;
    m = n % 64'sd720000000;
    if (m < 0) m = m + 64'sd720000000;
    q = m / 64'sd180000000;
    r = m % 64'sd180000000;
    th = (128'(r) * 128'h3243F6A8885A308D + 128'd90000000) / 128'd180000000;
    x = inv_gain;
    y = '0;
    rotate_vec(x, y, th[63:0]);
    case (q)
      0: begin c = x; s = y; end
      1: begin c = 64'd0 - y; s = x; end
      2: begin c = 64'd0 - x; s = 64'd0 - y; end
      default: begin c = y; s = 64'd0 - x; end
    endcase
  endtask

  function automatic logic [63:0] floor_sqrt(logic [127:0] n);
    logic [63:0] res;
    logic [63:0] c;
    res = '0;
    for (int b = 62; b >= 0; b--) begin
      c = res | (64'd1 << b);
      if (n >= 128'(c) * 128'(c)) res = c;
    end
    return res;
  endfunction

  // Great-circle distance of one pair at the given radius.
  task automatic predict_distance(input pair_t p, input logic [29:0] rad,
                                  output logic [31:0] d);
    longint la, loa, lb, lob;
    logic [63:0] ca, sa, cb, sb, ch, slat, slon, u, v, ra, rb, z;
    logic [127:0] sq, w, a, one, prod;
    la  = longint'($signed(p.la));
    loa = longint'($signed(p.loa));
    lb  = longint'($signed(p.lb));
    lob = longint'($signed(p.lob));
    sin_cos(2 * la, ca, sa);
    sin_cos(2 * lb, cb, sb);
    sin_cos(la - lb, ch, slat);
    sin_cos(loa - lob, ch, slon);
    u = 64'((128'(abs_q61(ca)) * 128'(abs_q61(cb)) + (128'd1 << 60)) >> 61);
    v = 64'((128'(u) * 128'(abs_q61(slon)) + (128'd1 << 60)) >> 61);
    w = 128'(v) * 128'(abs_q61(slon));
    sq = 128'(abs_q61(slat)) * 128'(abs_q61(slat));
    one = 128'd1 << 122;
    if (ca[63] ^ cb[63]) a = (sq < w) ? 128'd0 : sq - w;
    else a = sq + w;
    if (a > one) a = one;
    ra = floor_sqrt(a);
    rb = floor_sqrt(one - a);
    z = vector_angle(rb, ra);
    if (z[63]) z = '0;
    prod = 128'(rad) * 128'(z) + (128'd1 << 59);
    prod = prod >> 60;
    d = (prod > 128'hFFFFFFFF) ? 32'hFFFFFFFF : prod[31:0];
  endtask

  function automatic pair_t rand_pair();
    pair_t p;
    if ($urandom_range(9) == 0) begin
      p = 114'({$urandom, $urandom, $urandom, $urandom});
    end else begin
      p.la  = 28'(int'($urandom_range(180000000)) - 90000000);
      p.loa = 29'(int'($urandom_range(360000000)) - 180000000);
      p.lb  = 28'(int'($urandom_range(180000000)) - 90000000);
      p.lob = 29'(int'($urandom_range(360000000)) - 180000000);
      // Nearby points now and then, where sin(dlat/2) is tiny.
      if ($urandom_range(3) == 0) begin
        p.lb  = p.la + 28'($urandom_range(200)) - 28'd100;
        p.lob = p.loa + 29'($urandom_range(200)) - 29'd100;
      end
    end
    return p;
  endfunction

  task automatic queue_pair(pair_t p);
    pend_pairs.push_back(p);
    queued_cnt++;
  endtask

  task automatic wait_idle();
    while (done_cnt != queued_cnt) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_radius(logic [29:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    radius_cm = val;
  endtask

  // Input driver: predicts each accepted beat, then offers the next pair.
  always @(posedge clk) begin
    logic [31:0] d;
    cycle_cnt <= cycle_cnt + 1;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_distance({lat_a, lon_a, lat_b, lon_b}, radius_cm, d);
        dist_expected.push_back(d);
        accepted_cnt++;
      end
      if (pend_pairs.size() != 0 && !hold_send && $urandom_range(99) >= send_idle_pct) begin
        {lat_a, lon_a, lat_b, lon_b} <= pend_pairs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor and receiver stalls.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (dist_expected.size() == 0) begin
          $error("distance_cm beat with nothing expected: actual %0d", distance_cm);
          err_cnt++;
        end else begin
          if (distance_cm !== dist_expected[0]) begin
            $error("distance_cm mismatch: expected %0d actual %0d",
                   dist_expected[0], distance_cm);
            err_cnt++;
          end
          void'(dist_expected.pop_front());
        end
        done_cnt++;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (cycle_cnt > CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    logic [29:0] radii[N_PHASES];
    build_trig_tables();
    radii[0] = RADIUS_RESET;
    radii[1] = 30'd600000000;
    radii[2] = 30'd700000000;
    radii[3] = 30'h3FFFFFFF;
    radii[4] = 30'd0;
    radii[5] = 30'(600000000 + $urandom_range(100000000));
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed pairs: poles, antimeridian, antipodes, field extremes.
    queue_pair('{28'd0, 29'd0, 28'd0, 29'd0});
    queue_pair('{28'd90000000, 29'd0, -28'sd90000000, 29'd0});
    queue_pair('{28'd90000000, 29'd180000000, 28'd90000000, -29'sd180000000});
    queue_pair('{28'd0, 29'd0, 28'd0, 29'd180000000});
    queue_pair('{28'd0, -29'sd180000000, 28'd0, 29'd180000000});
    queue_pair('{28'd45000000, 29'd10000000, -28'sd45000000, -29'sd170000000});
    queue_pair('{28'd1, 29'd1, 28'd0, 29'd0});
    queue_pair('{28'd52000000, 29'd13000000, 28'd52000000, 29'd13000001});
    queue_pair('{28'h8000000, 29'h10000000, 28'h7FFFFFF, 29'h0FFFFFFF});
    queue_pair('{28'h7FFFFFF, 29'h0FFFFFFF, 28'h8000000, 29'h10000000});
    queue_pair('{28'hFFFFFFF, 29'h1FFFFFFF, 28'd0, 29'd0});
    queue_pair('{-28'sd90000000, -29'sd180000000, 28'd90000000, 29'd180000000});
    queue_pair('{28'd30000000, 29'd90000000, 28'd30000000, -29'sd90000000});

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph != 0) begin
        wait_idle();
        write_radius(radii[ph]);
      end
      case (ph / 2)
        0: begin send_idle_pct = 34; recv_idle_pct = 68; end
        1: begin send_idle_pct = 68; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int i = 0; i < PHASE_LEN; i++) queue_pair(rand_pair());
      // Halfway through one phase the sender holds until the pipe drains.
      if (ph == 1) begin
        while (pend_pairs.size() > PHASE_LEN / 2) @(posedge clk);
        hold_send = 1'b1;
        while (done_cnt != accepted_cnt || in_valid) @(posedge clk);
        hold_send = 1'b0;
      end
    end

    wait_idle();
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0 && dist_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (dist_expected.size() != 0)
        $error("%0d distance_cm beats never arrived", dist_expected.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
